### rtl/aes_pkg.sv
`default_nettype none
package aes_pkg;

    localparam int MaxRoundKeys = 15;

    typedef struct packed {
        logic        action;
        logic        restart;
        logic [63:0] data_high;
        logic [63:0] data_low;
    } aes_in_t;

    typedef struct packed {
        logic [63:0] result_high;
        logic [63:0] result_low;
    } aes_out_t;

    typedef enum logic [2:0] {
        REG_KEY0 = 3'd0,
        REG_KEY1 = 3'd1,
        REG_KEY2 = 3'd2,
        REG_KEY3 = 3'd3,
        REG_KLEN = 3'd4,
        REG_MODE = 3'd5,
        REG_IVH  = 3'd6,
        REG_IVL  = 3'd7
    } aes_reg_t;

    localparam logic [1:0] MODE_ECB = 2'd0;
    localparam logic [1:0] MODE_CBC = 2'd1;
    localparam logic [1:0] MODE_CFB = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_KEXP,
        ST_LOAD,
        ST_ROUND,
        ST_DONE
    } aes_state_t;

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] fwd_sbox(input logic [7:0] x);
        logic [7:0] t [256];
        t = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        return t[x];
    endfunction

    function automatic logic [7:0] inv_sbox(input logic [7:0] x);
        logic [7:0] t [256];
        t = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
        return t[x];
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {fwd_sbox(w[31:24]), fwd_sbox(w[23:16]), fwd_sbox(w[15:8]), fwd_sbox(w[7:0])};
    endfunction

    function automatic logic [7:0] gmul(input logic [7:0] a, input logic [3:0] b);
        logic [7:0] acc;
        logic [7:0] x;
        acc = 8'h00;
        x = a;
        for (int i = 0; i < 4; i++)
        begin
            if (b[i])
            begin
                acc = acc ^ x;
            end
            x = xtime(x);
        end
        return acc;
    endfunction

    // byte 0 of the state sits in bits [127:120]
    function automatic logic [127:0] enc_round(input logic [127:0] s, input logic last);
        logic [7:0] b [16];
        logic [7:0] t [16];
        logic [127:0] o;
        for (int i = 0; i < 16; i++)
        begin
            b[i] = s[127-8*i -: 8];
        end
        for (int c = 0; c < 4; c++)
        begin
            for (int j = 0; j < 4; j++)
            begin
                t[4*c+j] = fwd_sbox(b[4*((c+j)%4)+j]);
            end
        end
        for (int c = 0; c < 4; c++)
        begin
            if (last)
            begin
                o[127-32*c -: 32] = {t[4*c], t[4*c+1], t[4*c+2], t[4*c+3]};
            end
            else
            begin
                o[127-32*c -: 8] = gmul(t[4*c],4'd2) ^ gmul(t[4*c+1],4'd3) ^ t[4*c+2] ^ t[4*c+3];
                o[119-32*c -: 8] = t[4*c] ^ gmul(t[4*c+1],4'd2) ^ gmul(t[4*c+2],4'd3) ^ t[4*c+3];
                o[111-32*c -: 8] = t[4*c] ^ t[4*c+1] ^ gmul(t[4*c+2],4'd2) ^ gmul(t[4*c+3],4'd3);
                o[103-32*c -: 8] = gmul(t[4*c],4'd3) ^ t[4*c+1] ^ t[4*c+2] ^ gmul(t[4*c+3],4'd2);
            end
        end
        return o;
    endfunction

    // inverse shift and substitution
    function automatic logic [127:0] dec_sub(input logic [127:0] s);
        logic [7:0] b [16];
        logic [127:0] o;
        for (int i = 0; i < 16; i++)
        begin
            b[i] = s[127-8*i -: 8];
        end
        for (int c = 0; c < 4; c++)
        begin
            for (int j = 0; j < 4; j++)
            begin
                o[127-8*(4*c+j) -: 8] = inv_sbox(b[4*((c+4-j)%4)+j]);
            end
        end
        return o;
    endfunction

    function automatic logic [127:0] inv_mix(input logic [127:0] s);
        logic [7:0] a0, a1, a2, a3;
        logic [127:0] o;
        for (int c = 0; c < 4; c++)
        begin
            a0 = s[127-32*c -: 8];
            a1 = s[119-32*c -: 8];
            a2 = s[111-32*c -: 8];
            a3 = s[103-32*c -: 8];
            o[127-32*c -: 8] = gmul(a0,4'd14) ^ gmul(a1,4'd11) ^ gmul(a2,4'd13) ^ gmul(a3,4'd9);
            o[119-32*c -: 8] = gmul(a0,4'd9) ^ gmul(a1,4'd14) ^ gmul(a2,4'd11) ^ gmul(a3,4'd13);
            o[111-32*c -: 8] = gmul(a0,4'd13) ^ gmul(a1,4'd9) ^ gmul(a2,4'd14) ^ gmul(a3,4'd11);
            o[103-32*c -: 8] = gmul(a0,4'd11) ^ gmul(a1,4'd13) ^ gmul(a2,4'd9) ^ gmul(a3,4'd14);
        end
        return o;
    endfunction

endpackage
`default_nettype wire

### rtl/aes_keyexp.sv
`default_nettype none
module aes_keyexp
    import aes_pkg::*;
#(
    parameter int MAX_ROUND_KEYS = MaxRoundKeys,
    localparam int DEPTH = 2 * MAX_ROUND_KEYS,
    localparam int AW = $clog2(DEPTH)
)(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [255:0]  key,
    input  wire logic [1:0]    eff_len,
    output logic               busy,
    output logic               wr_en,
    output logic [AW-1:0]      wr_addr,
    output logic [63:0]        wr_data
);

    // sliding window of the last nk words, w[i-1] in bits [31:0]
    logic [255:0] win_reg;
    logic [255:0] win_next;
    logic [5:0]   idx_reg;
    logic [5:0]   idx_next;
    logic [7:0]   rc_reg;
    logic [7:0]   rc_next;
    logic [2:0]   cnt_reg;
    logic [2:0]   cnt_next;
    logic         busy_reg;
    logic         busy_next;
    logic         half_reg;
    logic         half_next;
    logic [31:0]  hold_reg;
    logic [31:0]  hold_next;
    logic [AW-1:0] addr_reg;
    logic [AW-1:0] addr_next;

    logic [3:0]  nk;
    logic [5:0]  total;
    logic [31:0] w_prev;
    logic [31:0] w_old;
    logic [31:0] t;
    logic [31:0] w_new;
    logic [31:0] emit;

    always_comb
    begin
        nk = 4'd4 + {1'b0, eff_len, 1'b0};
        total = 6'd4 * ({2'b00, nk} + 6'd7);
        w_prev = win_reg[31:0];
        w_old = win_reg[32*(nk-1) +: 32];
        t = w_prev;
        if (cnt_reg == 3'd0)
        begin
            t = sub_word({w_prev[23:0], w_prev[31:24]}) ^ {rc_reg, 24'h0};
        end
        else if (nk > 4'd6 && cnt_reg == 3'd4)
        begin
            t = sub_word(w_prev);
        end
        w_new = w_old ^ t;
        emit = (idx_reg < {2'b00, nk}) ? key[255 - 32*idx_reg[2:0] -: 32] : w_new;
    end

    always_comb
    begin
        win_next = win_reg;
        idx_next = idx_reg;
        rc_next = rc_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        half_next = half_reg;
        hold_next = hold_reg;
        addr_next = addr_reg;
        wr_en = 1'b0;
        wr_data = {hold_reg, emit};
        if (start)
        begin
            busy_next = 1'b1;
            idx_next = '0;
            rc_next = 8'h01;
            cnt_next = '0;
            half_next = 1'b0;
            addr_next = '0;
            win_next = '0;
        end
        else if (busy_reg)
        begin
            win_next = {win_reg[223:0], emit};
            if (idx_reg >= {2'b00, nk} && cnt_reg == 3'd0)
            begin
                rc_next = xtime(rc_reg);
            end
            if (idx_reg + 6'd1 == {2'b00, nk} || cnt_reg == nk[2:0] - 3'd1)
            begin
                cnt_next = 3'd0;
            end
            else
            begin
                cnt_next = cnt_reg + 3'd1;
            end
            half_next = ~half_reg;
            hold_next = emit;
            if (half_reg)
            begin
                wr_en = 1'b1;
                addr_next = addr_reg + AW'(1);
            end
            idx_next = idx_reg + 6'd1;
            if (idx_reg + 6'd1 == total || (half_reg && 32'(addr_reg) == DEPTH - 1))
            begin
                busy_next = 1'b0;
            end
        end
        wr_addr = addr_reg;
        busy = busy_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
        idx_reg <= idx_next;
        rc_reg <= rc_next;
        cnt_reg <= cnt_next;
        half_reg <= half_next;
        hold_reg <= hold_next;
        addr_reg <= addr_next;
    end

endmodule
`default_nettype wire

### rtl/aes_block_cipher_ecb_cbc_cfb.sv
`default_nettype none
// A word gets its first round key added in LOAD, runs Nr rounds in ROUND, leaves in DONE.
// Each round has a high-key and a low-key phase: round key halves come from a key memory with
// one read port, one word a cycle. A new word is taken only in IDLE; the result waits in an
// output register, so the next word is taken while it is held; a block that finishes early
// waits for it. A key or key length write starts a round key expansion; no word is taken then.
// Reset clears control and the chain value; the round key memory holds garbage until a key write.
module aes_block_cipher_ecb_cbc_cfb
    import aes_pkg::*;
#(
    parameter int MAX_ROUND_KEYS = MaxRoundKeys
)(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [5:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic      [63:0] prdata,
    output logic             pready,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire aes_in_t     in_data,
    output logic             out_valid,
    input  wire logic        out_stall,
    output aes_out_t         out_data
);

    localparam int DEPTH = 2 * MAX_ROUND_KEYS;
    localparam int AW = $clog2(DEPTH);
    localparam int CAP0 = (MAX_ROUND_KEYS - 11) / 2;
    localparam logic [1:0] CAP = (CAP0 > 2) ? 2'd2 : 2'(CAP0);

    logic [63:0] key_reg [4];
    logic [1:0]  klen_reg;
    logic [1:0]  mode_reg;
    logic [63:0] ivh_reg;
    logic [63:0] ivl_reg;
    logic [127:0] chain_reg;
    logic [127:0] chain_next;

    logic [63:0] rk_mem [DEPTH];
    logic [63:0] rk_q;
    logic [AW-1:0] rd_addr;

    aes_state_t  state_reg;
    aes_state_t  state_next;
    logic [127:0] st_reg;
    logic [127:0] st_next;
    logic [63:0]  khi_reg;
    logic [63:0]  khi_next;
    logic [4:0]   rnd_reg;
    logic [4:0]   rnd_next;
    logic         ph_reg;
    logic         ph_next;
    logic         dec_reg;
    logic         dec_next;
    logic [127:0] din_reg;
    logic [127:0] din_next;
    logic [127:0] v_reg;
    logic [127:0] v_next;
    logic         encblk_reg;
    logic         encblk_next;
    aes_out_t     res_reg;
    aes_out_t     res_next;
    logic         out_valid_reg;
    logic         out_valid_next;
    logic         out_free;

    logic         wr;
    logic [2:0]   wr_idx;
    logic         kx_start;
    logic         kx_busy;
    logic         kx_we;
    logic [AW-1:0] kx_addr;
    logic [63:0]  kx_data;
    logic [1:0]   eff_len;
    logic [4:0]   nr;
    logic [127:0] rk;
    logic         accept;

    assign pready = 1'b1;
    assign wr = psel && penable && pwrite;
    assign wr_idx = paddr[5:3];
    assign kx_start = wr && (wr_idx == REG_KEY0 || wr_idx == REG_KEY1 || wr_idx == REG_KEY2 ||
                             wr_idx == REG_KEY3 || wr_idx == REG_KLEN);

    always_comb
    begin
        eff_len = (klen_reg == 2'd3) ? 2'd2 : klen_reg;
        if (eff_len > CAP)
        begin
            eff_len = CAP;
        end
        nr = 5'd10 + {2'b00, eff_len, 1'b0};
    end

    always_comb
    begin
        unique case (aes_reg_t'(paddr[5:3]))
            REG_KEY0: prdata = key_reg[0];
            REG_KEY1: prdata = key_reg[1];
            REG_KEY2: prdata = key_reg[2];
            REG_KEY3: prdata = key_reg[3];
            REG_KLEN: prdata = {62'h0, klen_reg};
            REG_MODE: prdata = {62'h0, mode_reg};
            REG_IVH:  prdata = ivh_reg;
            REG_IVL:  prdata = ivl_reg;
            default:  prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg[0] <= '0;
            key_reg[1] <= '0;
            key_reg[2] <= '0;
            key_reg[3] <= '0;
            klen_reg <= '0;
            mode_reg <= '0;
            ivh_reg <= '0;
            ivl_reg <= '0;
        end
        else if (wr)
        begin
            unique case (aes_reg_t'(wr_idx))
                REG_KEY0: key_reg[0] <= pwdata;
                REG_KEY1: key_reg[1] <= pwdata;
                REG_KEY2: key_reg[2] <= pwdata;
                REG_KEY3: key_reg[3] <= pwdata;
                REG_KLEN: klen_reg <= pwdata[1:0];
                REG_MODE: mode_reg <= pwdata[1:0];
                REG_IVH:  ivh_reg <= pwdata;
                REG_IVL:  ivl_reg <= pwdata;
                default:  ;
            endcase
        end
    end

    logic [1:0] kx_len;
    logic [255:0] kx_key;
    always_comb
    begin
        kx_key = {key_reg[0], key_reg[1], key_reg[2], key_reg[3]};
        kx_len = eff_len;
        if (wr && wr_idx < 3'd4)
        begin
            kx_key[255 - 64*wr_idx -: 64] = pwdata;
        end
        if (wr && wr_idx == REG_KLEN)
        begin
            kx_len = (pwdata[1:0] == 2'd3) ? 2'd2 : pwdata[1:0];
            if (kx_len > CAP)
            begin
                kx_len = CAP;
            end
        end
    end

    logic [255:0] kx_key_reg;
    logic [1:0]   kx_len_reg;
    logic         kx_go_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kx_go_reg <= 1'b0;
        end
        else
        begin
            kx_go_reg <= kx_start;
        end
    end
    always_ff @(posedge clk)
    begin
        if (kx_start)
        begin
            kx_key_reg <= kx_key;
            kx_len_reg <= kx_len;
        end
    end

    aes_keyexp #(
        .MAX_ROUND_KEYS(MAX_ROUND_KEYS)
    ) u_keyexp (
        .clk(clk),
        .rst_n(rst_n),
        .start(kx_go_reg),
        .key(kx_key_reg),
        .eff_len(kx_len_reg),
        .busy(kx_busy),
        .wr_en(kx_we),
        .wr_addr(kx_addr),
        .wr_data(kx_data)
    );

    always_ff @(posedge clk)
    begin
        if (kx_we)
        begin
            rk_mem[kx_addr] <= kx_data;
        end
        rk_q <= rk_mem[rd_addr];
    end

    assign accept = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE) || kx_busy || kx_go_reg || kx_start;
    assign out_free = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign out_data = res_reg;
    assign rk = {khi_reg, rk_q};

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (accept) state_next = ST_LOAD;
            ST_KEXP:  state_next = ST_IDLE;
            ST_LOAD:  if (ph_reg) state_next = ST_ROUND;
            ST_ROUND: if (ph_reg && rnd_reg == nr) state_next = ST_DONE;
            ST_DONE:  if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // key memory read is registered, address set ahead: phase 0 reads high half, phase 1 low half
    logic [4:0] key_round;
    always_comb
    begin
        key_round = encblk_reg ? rnd_reg : (nr - rnd_reg);
        rd_addr = AW'(2 * key_round + {4'h0, ph_reg});
        if (state_reg == ST_IDLE)
        begin
            rd_addr = AW'(0);
            if (accept && in_data.action && !(mode_reg == MODE_CFB))
            begin
                rd_addr = AW'(2 * nr);
            end
        end
        else
        begin
            key_round = ph_reg ? ((encblk_reg ? rnd_reg + 5'd1 : nr - rnd_reg - 5'd1))
                               : key_round;
            rd_addr = AW'(2 * key_round + {4'h0, ~ph_reg});
        end
    end

    logic [127:0] src;
    always_comb
    begin
        st_next = st_reg;
        khi_next = khi_reg;
        rnd_next = rnd_reg;
        ph_next = ph_reg;
        dec_next = dec_reg;
        din_next = din_reg;
        v_next = v_reg;
        encblk_next = encblk_reg;
        res_next = res_reg;
        chain_next = chain_reg;
        src = '0;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    dec_next = in_data.action;
                    din_next = {in_data.data_high, in_data.data_low};
                    v_next = in_data.restart ? {ivh_reg, ivl_reg} : chain_reg;
                    encblk_next = !in_data.action || mode_reg == MODE_CFB;
                    unique case (mode_reg)
                        MODE_CBC: src = in_data.action ? din_next : (din_next ^ v_next);
                        MODE_CFB: src = v_next;
                        default:  src = din_next;
                    endcase
                    st_next = src;
                    rnd_next = '0;
                    ph_next = 1'b0;
                end
            end
            ST_LOAD:
            begin
                if (!ph_reg)
                begin
                    khi_next = rk_q;
                    ph_next = 1'b1;
                end
                else
                begin
                    st_next = st_reg ^ {khi_reg, rk_q};
                    if (!encblk_reg)
                    begin
                        st_next = dec_sub(st_reg ^ {khi_reg, rk_q});
                    end
                    rnd_next = 5'd1;
                    ph_next = 1'b0;
                end
            end
            ST_ROUND:
            begin
                if (!ph_reg)
                begin
                    khi_next = rk_q;
                    ph_next = 1'b1;
                end
                else
                begin
                    ph_next = 1'b0;
                    rnd_next = rnd_reg + 5'd1;
                    if (encblk_reg)
                    begin
                        st_next = enc_round(st_reg, rnd_reg == nr) ^ rk;
                    end
                    else if (rnd_reg == nr)
                    begin
                        st_next = st_reg ^ rk;
                    end
                    else
                    begin
                        st_next = dec_sub(inv_mix(st_reg ^ rk));
                    end
                    if (rnd_reg == nr)
                    begin
                        unique case (mode_reg)
                            MODE_CBC:
                            begin
                                src = dec_reg ? (st_next ^ v_reg) : st_next;
                                chain_next = dec_reg ? din_reg : src;
                            end
                            MODE_CFB:
                            begin
                                src = st_next ^ din_reg;
                                chain_next = dec_reg ? din_reg : src;
                            end
                            default:
                            begin
                                src = st_next;
                                chain_next = v_reg;
                            end
                        endcase
                        st_next = src;
                    end
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    res_next = st_reg;
                    out_valid_next = 1'b1;
                end
            end
            default: ;
        endcase
        if (state_reg == ST_IDLE && accept && mode_reg != MODE_CBC && mode_reg != MODE_CFB)
        begin
            chain_next = v_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            chain_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            chain_reg <= chain_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        st_reg <= st_next;
        khi_reg <= khi_next;
        rnd_reg <= rnd_next;
        ph_reg <= ph_next;
        dec_reg <= dec_next;
        din_reg <= din_next;
        v_reg <= v_next;
        encblk_reg <= encblk_next;
        res_reg <= res_next;
    end

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        kx_busy |-> !accept) else $error("word taken during key expansion");
    a_no_kx_in_work: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND) |-> !kx_we) else $error("key memory written mid block");
    a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(res_reg)))
        else $error("result dropped");
    a_round_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND) |-> (rnd_reg <= nr)) else $error("round overrun");

endmodule
`default_nettype wire

### tb/sv/tb_aes_block_cipher_ecb_cbc_cfb.sv
`default_nettype none
module tb_aes_block_cipher_ecb_cbc_cfb;
    import aes_pkg::*;

    localparam logic ACT_ENC = 1'b0;
    localparam logic ACT_DEC = 1'b1;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int KEY_SETTLE = 80;
    localparam int DRAIN_CYCLES = 40;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [5:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_stall;
    aes_in_t     in_data;
    logic        out_valid;
    logic        out_stall;
    aes_out_t    out_data;

    aes_block_cipher_ecb_cbc_cfb DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    logic [7:0]   sub_tab [256];
    logic [7:0]   unsub_tab [256];
    logic [63:0]  key_reg [4];
    logic [1:0]   klen_reg;
    logic [1:0]   mode_reg;
    logic [63:0]  iv_hi_reg;
    logic [63:0]  iv_lo_reg;
    logic [63:0]  sched [30];
    logic [127:0] chain_val;

    aes_out_t     pending_blocks [$];
    int           mismatches;
    int           words_sent;
    int           blocks_checked;
    int           cycle_count;
    int           send_idle_pct;
    int           recv_stall_pct;
    int           hold_cnt;

    initial clk = 1'b0;
    always #4 clk = ~clk;

    function automatic logic [7:0] gf_x2(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gf_prod(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        logic [7:0] x;
        acc = 8'h00;
        x = a;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i])
            begin
                acc = acc ^ x;
            end
            x = gf_x2(x);
        end
        return acc;
    endfunction

    function automatic void build_sboxes();
        logic [7:0] p;
        logic [7:0] s;
        for (int a = 0; a < 256; a++)
        begin
            p = 8'h01;
            for (int k = 0; k < 254; k++)
            begin
                p = gf_prod(p, a[7:0]);
            end
            s = p ^ {p[6:0], p[7]} ^ {p[5:0], p[7:6]} ^ {p[4:0], p[7:5]} ^ {p[3:0], p[7:4]};
            sub_tab[a] = s ^ 8'h63;
            unsub_tab[sub_tab[a]] = a[7:0];
        end
    endfunction

    function automatic int eff_klen();
        return (klen_reg > 2'd2) ? 2 : int'(klen_reg);
    endfunction

    function automatic void expand_schedule();
        logic [31:0] w [60];
        logic [31:0] t;
        logic [7:0]  rc;
        int          nk;
        int          total;
        nk = 4 + 2 * eff_klen();
        total = 4 * (nk + 7);
        rc = 8'h01;
        for (int i = 0; i < 60; i++)
        begin
            w[i] = 32'h0;
        end
        for (int i = 0; i < nk; i++)
        begin
            w[i] = (i % 2 == 0) ? key_reg[i / 2][63:32] : key_reg[i / 2][31:0];
        end
        for (int i = nk; i < total; i++)
        begin
            t = w[i - 1];
            if (i % nk == 0)
            begin
                t = {t[23:0], t[31:24]};
                t = {sub_tab[t[31:24]], sub_tab[t[23:16]], sub_tab[t[15:8]], sub_tab[t[7:0]]};
                t = t ^ {rc, 24'h0};
                rc = gf_x2(rc);
            end
            else if (nk > 6 && i % nk == 4)
            begin
                t = {sub_tab[t[31:24]], sub_tab[t[23:16]], sub_tab[t[15:8]], sub_tab[t[7:0]]};
            end
            w[i] = w[i - nk] ^ t;
        end
        for (int i = 0; i < total / 2 && i < 30; i++)
        begin
            sched[i] = {w[2 * i], w[2 * i + 1]};
        end
    endfunction

    function automatic logic [127:0] round_key(input int r);
        return {sched[(2 * r) % 30], sched[(2 * r) % 30 + 1]};
    endfunction

    function automatic logic [127:0] cipher_fwd(input logic [127:0] blk, input int nr);
        logic [7:0]   b [16];
        logic [7:0]   t [16];
        logic [127:0] s;
        s = blk ^ round_key(0);
        for (int r = 1; r <= nr; r++)
        begin
            for (int i = 0; i < 16; i++)
            begin
                b[i] = s[127 - 8 * i -: 8];
            end
            for (int c = 0; c < 4; c++)
            begin
                for (int j = 0; j < 4; j++)
                begin
                    t[4 * c + j] = sub_tab[b[4 * ((c + j) % 4) + j]];
                end
            end
            for (int c = 0; c < 4; c++)
            begin
                if (r == nr)
                begin
                    s[127 - 32 * c -: 32] = {t[4 * c], t[4 * c + 1], t[4 * c + 2], t[4 * c + 3]};
                end
                else
                begin
                    for (int j = 0; j < 4; j++)
                    begin
                        s[127 - 32 * c - 8 * j -: 8] =
                            gf_prod(t[4 * c + j], 8'd2) ^ gf_prod(t[4 * c + (j + 1) % 4], 8'd3)
                            ^ t[4 * c + (j + 2) % 4] ^ t[4 * c + (j + 3) % 4];
                    end
                end
            end
            s = s ^ round_key(r);
        end
        return s;
    endfunction

    function automatic logic [127:0] cipher_inv(input logic [127:0] blk, input int nr);
        logic [7:0]   b [16];
        logic [7:0]   t [16];
        logic [127:0] s;
        logic [127:0] u;
        s = blk ^ round_key(nr);
        for (int r = nr - 1; r >= 0; r--)
        begin
            for (int i = 0; i < 16; i++)
            begin
                b[i] = s[127 - 8 * i -: 8];
            end
            for (int c = 0; c < 4; c++)
            begin
                for (int j = 0; j < 4; j++)
                begin
                    u[127 - 8 * (4 * c + j) -: 8] = unsub_tab[b[4 * ((c + 4 - j) % 4) + j]];
                end
            end
            u = u ^ round_key(r);
            if (r == 0)
            begin
                s = u;
            end
            else
            begin
                for (int i = 0; i < 16; i++)
                begin
                    t[i] = u[127 - 8 * i -: 8];
                end
                for (int c = 0; c < 4; c++)
                begin
                    for (int j = 0; j < 4; j++)
                    begin
                        s[127 - 32 * c - 8 * j -: 8] =
                            gf_prod(t[4 * c + j], 8'd14) ^ gf_prod(t[4 * c + (j + 1) % 4], 8'd11)
                            ^ gf_prod(t[4 * c + (j + 2) % 4], 8'd13)
                            ^ gf_prod(t[4 * c + (j + 3) % 4], 8'd9);
                    end
                end
            end
        end
        return s;
    endfunction

    function automatic aes_out_t predict_block(input aes_in_t w);
        logic [127:0] d;
        logic [127:0] r;
        int           nr;
        aes_out_t     o;
        nr = 10 + 2 * eff_klen();
        d = {w.data_high, w.data_low};
        if (w.restart)
        begin
            chain_val = {iv_hi_reg, iv_lo_reg};
        end
        if (mode_reg == MODE_CBC)
        begin
            if (w.action == ACT_DEC)
            begin
                r = cipher_inv(d, nr) ^ chain_val;
                chain_val = d;
            end
            else
            begin
                r = cipher_fwd(d ^ chain_val, nr);
                chain_val = r;
            end
        end
        else if (mode_reg == MODE_CFB)
        begin
            r = cipher_fwd(chain_val, nr) ^ d;
            chain_val = (w.action == ACT_DEC) ? d : r;
        end
        else
        begin
            r = (w.action == ACT_DEC) ? cipher_inv(d, nr) : cipher_fwd(d, nr);
        end
        o.result_high = r[127:64];
        o.result_low = r[63:0];
        return o;
    endfunction

    always @(posedge clk)
    begin
        aes_out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            blocks_checked++;
            if (pending_blocks.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("unexpected result %h %h", out_data.result_high, out_data.result_low);
                end
            end
            else
            begin
                want = pending_blocks.pop_front();
                if (want.result_high !== out_data.result_high
                    || want.result_low !== out_data.result_low)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("mismatch: expected %h %h, got %h %h", want.result_high,
                                 want.result_low, out_data.result_high, out_data.result_low);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cnt > 0)
            begin
                out_stall = 1'b1;
                hold_cnt--;
            end
            else
            begin
                out_stall = ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    task automatic send_word(input logic act, input logic rst_chain,
                             input logic [63:0] hi, input logic [63:0] lo);
        aes_in_t w;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        w.action = act;
        w.restart = rst_chain;
        w.data_high = hi;
        w.data_low = lo;
        in_data = w;
        in_valid = 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        pending_blocks.push_back(predict_block(w));
        words_sent++;
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid = 1'b0;
        while (pending_blocks.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input aes_reg_t idx, input logic [63:0] val);
        drain();
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = {idx, 3'b000};
        pwdata = val;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        case (idx)
            REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3:
            begin
                key_reg[idx] = val;
                expand_schedule();
            end
            REG_KLEN:
            begin
                klen_reg = val[1:0];
                expand_schedule();
            end
            REG_MODE: mode_reg = val[1:0];
            REG_IVH:  iv_hi_reg = val;
            default:  iv_lo_reg = val;
        endcase
        if (idx <= REG_KLEN)
        begin
            repeat (KEY_SETTLE) @(negedge clk);
        end
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic load_random_setup();
        write_reg(REG_KEY0, rand64());
        write_reg(REG_KEY1, rand64());
        write_reg(REG_KEY2, rand64());
        write_reg(REG_KEY3, rand64());
        write_reg(REG_KLEN, 64'($urandom_range(3)));
        write_reg(REG_MODE, 64'($urandom_range(3)));
        write_reg(REG_IVH, rand64());
        write_reg(REG_IVL, rand64());
    endtask

    task automatic test_directed();
        write_reg(REG_KEY0, 64'h0001020304050607);
        write_reg(REG_KEY1, 64'h08090a0b0c0d0e0f);
        write_reg(REG_KEY2, 64'h1011121314151617);
        write_reg(REG_KEY3, 64'h18191a1b1c1d1e1f);
        for (int kl = 0; kl < 4; kl++)
        begin
            write_reg(REG_KLEN, 64'(kl));
            send_word(ACT_ENC, 1'b0, 64'h0011223344556677, 64'h8899aabbccddeeff);
            send_word(ACT_DEC, 1'b0, '1, '1);
        end
        write_reg(REG_KLEN, 64'(0));
        send_word(ACT_ENC, 1'b0, 64'h0, 64'h0);
        // chain value from reset, then from the IV
        write_reg(REG_MODE, 64'(MODE_CBC));
        send_word(ACT_ENC, 1'b0, 64'h0, 64'h0);
        write_reg(REG_IVH, '1);
        write_reg(REG_IVL, 64'h8000000000000001);
        send_word(ACT_ENC, 1'b1, '1, 64'h0);
        send_word(ACT_ENC, 1'b0, 64'h0, '1);
        send_word(ACT_DEC, 1'b1, 64'h0123456789abcdef, 64'hfedcba9876543210);
        send_word(ACT_DEC, 1'b0, '1, '1);
        write_reg(REG_MODE, 64'(MODE_CFB));
        send_word(ACT_ENC, 1'b1, 64'h0, 64'h0);
        send_word(ACT_ENC, 1'b0, '1, '1);
        send_word(ACT_DEC, 1'b1, 64'h0, '1);
        send_word(ACT_DEC, 1'b0, '1, 64'h0);
        write_reg(REG_MODE, 64'(2'd3));
        send_word(ACT_ENC, 1'b1, 64'h5555aaaa5555aaaa, 64'haaaa5555aaaa5555);
        send_word(ACT_DEC, 1'b0, 64'h5555aaaa5555aaaa, 64'haaaa5555aaaa5555);
        drain();
    endtask

    task automatic test_random();
        int pcts [4][2];
        pcts = '{'{0, 0}, '{63, 0}, '{0, 63}, '{16, 16}};
        for (int ph = 0; ph < 4; ph++)
        begin
            for (int set = 0; set < 3; set++)
            begin
                load_random_setup();
                send_idle_pct = pcts[ph][0];
                recv_stall_pct = pcts[ph][1];
                for (int n = 0; n < 88; n++)
                begin
                    send_word(1'($urandom_range(1)), ($urandom_range(7) == 0),
                              rand64(), rand64());
                end
                drain();
                send_idle_pct = 0;
                recv_stall_pct = 0;
            end
        end
    endtask

    task automatic test_backpressure();
        write_reg(REG_MODE, 64'(MODE_CBC));
        hold_cnt = 500;
        for (int n = 0; n < 12; n++)
        begin
            send_word(1'($urandom_range(1)), (n == 0), rand64(), rand64());
        end
        drain();
    endtask

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_valid = 1'b0;
        in_data = '0;
        mismatches = 0;
        words_sent = 0;
        blocks_checked = 0;
        cycle_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_cnt = 0;
        for (int i = 0; i < 4; i++)
        begin
            key_reg[i] = '0;
        end
        for (int i = 0; i < 30; i++)
        begin
            sched[i] = '0;
        end
        klen_reg = '0;
        mode_reg = MODE_ECB;
        iv_hi_reg = '0;
        iv_lo_reg = '0;
        chain_val = '0;
        build_sboxes();
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed();
        test_random();
        test_backpressure();
        $display("%0d words sent, %0d blocks checked over all key sizes and chaining modes",
                 words_sent, blocks_checked);
        $display("idle, sender-gap, receiver-stall and long hold-off phases; %0d mismatches",
                 mismatches);
        if (mismatches == 0 && pending_blocks.size() == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
`default_nettype wire
